[rtl/lodd_pkg.sv]
package lodd_pkg;

  localparam int unsigned MaxThreads = 8;
  localparam int unsigned MaxMutexes = 8;
  localparam int unsigned TW = $clog2(MaxThreads);
  localparam int unsigned MW = $clog2(MaxMutexes);
  localparam int unsigned TCW = $clog2(MaxThreads + 1);
  localparam int unsigned MCW = $clog2(MaxMutexes + 1);
  localparam int unsigned IdW = 64;
  localparam int unsigned StW = 3;
  localparam int unsigned SlotW = 3;

  localparam logic [StW-1:0] StOk = 3'd0;
  localparam logic [StW-1:0] StThreadFull = 3'd1;
  localparam logic [StW-1:0] StMutexFull = 3'd2;
  localparam logic [StW-1:0] StUnknown = 3'd3;
  localparam logic [StW-1:0] StHeldFull = 3'd4;

  localparam logic OpLock = 1'b0;
  localparam logic OpRelease = 1'b1;

  typedef logic [MaxMutexes-1:0] row_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic clos_init;
    logic clos_step;
    logic clos_done;
  } dp_cmd_t;

  typedef struct packed {
    logic last_k;
    logic no_update;
  } dp_sts_t;

  typedef struct packed {
    logic [StW-1:0]   status;
    logic             deadlock;
    logic [SlotW-1:0] thread_slot;
    logic [SlotW-1:0] mutex_slot;
  } result_t;

endpackage

[rtl/lock_order_deadlock_detector_core.sv]
// channel   dir  tdata (low bit up)                           tuser
// s_axis    in   thread_id[63:0], mutex_addr[127:64]          op
// m_axis    out  status[2:0], deadlock[3], thread_slot[6:4],  -
//                mutex_slot[9:7]
// one event at a time: load, table lookup register, update, then for
// an ok event a closure init and one closure step per mutex slot; a
// rejected event goes from the update straight to output
// the closure loop over mutex slots is the longest part; output stalls add on
// reset clears counts, held flags and edges; stalled output holds the block
module lock_order_deadlock_detector_core import lodd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // thread_id, mutex_addr
  input  logic         s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata   // status, deadlock, thread_slot, mutex_slot
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  result_t res;

  lodd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .sts_i(sts)
  );

  lodd_dp u_dp (
    .clk_i, .rst_ni,
    .op_i(s_axis_tuser),
    .thread_id_i(s_axis_tdata[63:0]),
    .mutex_addr_i(s_axis_tdata[127:64]),
    .cmd_i(cmd), .sts_o(sts), .res_o(res)
  );

  assign m_axis_tdata = {6'd0, res.mutex_slot, res.thread_slot, res.deadlock, res.status};

endmodule

[rtl/lodd_ctrl.sv]
module lodd_ctrl import lodd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [2:0] {SIdle, SApply, SInit, SStep, SOut} state_e;

  state_e state_q;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    cmd_o = '0;
    cmd_o.load      = (state_q == SIdle) && in_valid_i;
    cmd_o.apply     = (state_q == SApply);
    cmd_o.clos_init = (state_q == SInit);
    cmd_o.clos_step = (state_q == SStep);
    cmd_o.clos_done = (state_q == SStep) && sts_i.last_k;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      unique case (state_q)
        SIdle: if (in_valid_i) state_q <= SApply;
        SApply: state_q <= sts_i.no_update ? SOut : SInit;
        SInit: state_q <= SStep;
        SStep: if (sts_i.last_k) state_q <= SOut;
        SOut: if (out_ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

[rtl/lodd_dp.sv]
module lodd_dp import lodd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_i,
  input  logic [IdW-1:0] thread_id_i,
  input  logic [IdW-1:0] mutex_addr_i,
  input  dp_cmd_t        cmd_i,
  output dp_sts_t        sts_o,
  output result_t        res_o
);

  logic [IdW-1:0] tid_q [MaxThreads];
  logic [IdW-1:0] mad_q [MaxMutexes];
  logic [TCW-1:0] tcnt_q;
  logic [MCW-1:0] mcnt_q;
  logic [MaxMutexes-1:0][MW-1:0] held_q [MaxThreads];
  logic [MaxMutexes-1:0] hv_q [MaxThreads];
  row_t edges_q [MaxMutexes];
  row_t reach_q [MaxMutexes];
  logic [MW-1:0]  k_q;
  logic           op_q;
  logic [IdW-1:0] tin_q, min_q;
  result_t        res_q;

  // lookup, registered at load
  logic           thit, mhit;
  logic [TW-1:0]  tfound;
  logic [MW-1:0]  mfound;

  always_comb begin
    thit = 1'b0;
    tfound = '0;
    for (int i = MaxThreads - 1; i >= 0; i--) begin
      if (TCW'(i) < tcnt_q && tid_q[i] == thread_id_i) begin
        thit = 1'b1;
        tfound = TW'(i);
      end
    end
    mhit = 1'b0;
    mfound = '0;
    for (int i = MaxMutexes - 1; i >= 0; i--) begin
      if (MCW'(i) < mcnt_q && mad_q[i] == mutex_addr_i) begin
        mhit = 1'b1;
        mfound = MW'(i);
      end
    end
  end

  logic          thit_q, mhit_q;
  logic [TW-1:0] tf_q;
  logic [MW-1:0] mf_q;

  // decision over registered lookup
  logic [TW-1:0] ts;
  logic [MW-1:0] ms;
  logic          t_new, m_new, held_full, rel_hit, do_lock, do_rel;
  logic [MW-1:0] empty_j, hit_j;
  logic [MaxMutexes-1:0] tv;
  row_t          src_rows;
  logic [StW-1:0] st;

  always_comb begin
    ts = thit_q ? tf_q : TW'(tcnt_q);
    ms = mhit_q ? mf_q : MW'(mcnt_q);
    t_new = 1'b0;
    m_new = 1'b0;
    do_lock = 1'b0;
    do_rel = 1'b0;
    tv = hv_q[ts];
    held_full = &tv;
    empty_j = '0;
    for (int j = MaxMutexes - 1; j >= 0; j--) begin
      if (!tv[j]) empty_j = MW'(j);
    end
    rel_hit = 1'b0;
    hit_j = '0;
    for (int j = MaxMutexes - 1; j >= 0; j--) begin
      if (tv[j] && held_q[ts][j] == ms) begin
        rel_hit = 1'b1;
        hit_j = MW'(j);
      end
    end
    // rows of the mutexes the thread holds
    src_rows = '0;
    for (int j = 0; j < MaxMutexes; j++) begin
      if (tv[j]) src_rows[held_q[ts][j]] = 1'b1;
    end
    st = StOk;
    if (op_q == OpLock) begin
      if (!thit_q && tcnt_q >= TCW'(MaxThreads)) begin
        st = StThreadFull;
      end else begin
        t_new = !thit_q;
        if (!mhit_q && mcnt_q >= MCW'(MaxMutexes)) begin
          st = StMutexFull;
        end else begin
          m_new = !mhit_q;
          if (held_full) st = StHeldFull;
          else do_lock = 1'b1;
        end
      end
    end else begin
      if (!thit_q || !mhit_q || !rel_hit) st = StUnknown;
      else do_rel = 1'b1;
    end
  end

  // closure step: rows holding bit k take row k
  row_t step_rows [MaxMutexes];
  logic cyc;
  always_comb begin
    cyc = 1'b0;
    for (int i = 0; i < MaxMutexes; i++) begin
      step_rows[i] = reach_q[i][k_q] ? (reach_q[i] | reach_q[k_q]) : reach_q[i];
      if (step_rows[i][i]) cyc = 1'b1;
    end
  end

  assign sts_o.last_k    = (k_q == MW'(MaxMutexes - 1));
  assign sts_o.no_update = !(do_lock || do_rel);
  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      tin_q <= thread_id_i;
      min_q <= mutex_addr_i;
      thit_q <= thit;
      mhit_q <= mhit;
      tf_q <= tfound;
      mf_q <= mfound;
    end
    if (cmd_i.apply) begin
      if (t_new) tid_q[ts] <= tin_q;
      if (m_new) mad_q[ms] <= min_q;
      if (do_lock) held_q[ts][empty_j] <= ms;
      res_q.status <= st;
      res_q.deadlock <= 1'b0;
      res_q.thread_slot <= (st == StThreadFull) ? '0
                         : (op_q != OpLock && !thit_q) ? '0 : SlotW'(ts);
      res_q.mutex_slot <= (st == StThreadFull || st == StMutexFull) ? '0
                        : (op_q != OpLock && !mhit_q) ? '0 : SlotW'(ms);
    end
    if (cmd_i.clos_init) begin
      for (int i = 0; i < MaxMutexes; i++) reach_q[i] <= edges_q[i];
    end
    if (cmd_i.clos_step) begin
      for (int i = 0; i < MaxMutexes; i++) reach_q[i] <= step_rows[i];
    end
    if (cmd_i.clos_done) res_q.deadlock <= cyc && (op_q == OpLock);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcnt_q <= '0;
      mcnt_q <= '0;
      k_q <= '0;
      for (int i = 0; i < MaxThreads; i++) hv_q[i] <= '0;
      for (int i = 0; i < MaxMutexes; i++) edges_q[i] <= '0;
    end else begin
      if (cmd_i.clos_init) k_q <= '0;
      else if (cmd_i.clos_step) k_q <= k_q + MW'(1);
      if (cmd_i.apply) begin
        if (t_new) tcnt_q <= tcnt_q + TCW'(1);
        if (m_new) mcnt_q <= mcnt_q + MCW'(1);
        if (do_lock) hv_q[ts][empty_j] <= 1'b1;
        if (do_rel) hv_q[ts][hit_j] <= 1'b0;
        if (do_lock || do_rel) begin
          for (int i = 0; i < MaxMutexes; i++) begin
            if (src_rows[i]) edges_q[i][ms] <= do_lock;
          end
        end
      end
    end
  end

endmodule

[rtl/lodd_checker.sv]
module lodd_checker import lodd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready during output");

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("accept twice");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= StHeldFull) else $error("bad status");

  a_dead_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:0] == StOk)
    else $error("deadlock on error");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped");

endmodule

bind lock_order_deadlock_detector_core lodd_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
